>>> sv/msrb_pkg.sv
// Package for the multichannel serial ring buffers: item types, control struct and codes.
// Used by every module of the block; depends on nothing else.
package msrb_pkg;

  // Default sizes handed to the top level parameters.
  localparam int CHANNELS_DEF   = 8;
  localparam int RING_BYTES_DEF = 4096;

  // Widths fixed by the item fields and the configuration port.
  localparam int COUNT_W    = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // Access commands.
  localparam logic [1:0] CMD_HOST_TX_WRITE = 2'd0;
  localparam logic [1:0] CMD_HOST_RX_READ  = 2'd1;
  localparam logic [1:0] CMD_LINE_RX_PUT   = 2'd2;
  localparam logic [1:0] CMD_LINE_TX_TAKE  = 2'd3;

  // Result status codes.
  localparam logic [1:0] STATUS_DONE    = 2'd0;
  localparam logic [1:0] STATUS_RING    = 2'd1;
  localparam logic [1:0] STATUS_REFUSED = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OPEN_MASK     = 2'd1;

  // Ring selector within a channel.
  localparam logic RING_RX = 1'b0;
  localparam logic RING_TX = 1'b1;

  // One access item.
  typedef struct packed {
    logic [1:0] cmd;
    logic [2:0] channel;
    logic [7:0] data_in;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [7:0]         data_out;
    logic [1:0]         status;
    logic [COUNT_W-1:0] rx_count;
    logic [COUNT_W-1:0] tx_room;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic exec;
    logic resp;
  } ctl_t;

endpackage

>>> sv/multichannel_serial_ring_buffers.sv
// Top level of the multichannel serial ring buffers: joins controller and datapath.
// Depends on msrb_pkg, msrb_ctrl and msrb_datapath.
//
//   Channel        Signals                          Accepted when
//   access item    start, busy, item                start high and busy low
//   result item    done, result                     done high (one cycle, no stall)
//   configuration  cfg_we, cfg_index, cfg_data      cfg_we high
//
// An item passes through an execute phase, which reads the channel's pointers and
// accesses the ring memory, and a respond phase, which shows the result while the
// registered memory read data is valid. A new item may enter during the respond phase.
// Synchronous reset initialises the pointers and configuration; ring memory is not cleared.
// The result is shown for one cycle only; the receiver cannot hold it off.
module multichannel_serial_ring_buffers
  import msrb_pkg::*;
#(
  parameter int CHANNELS   = CHANNELS_DEF,
  parameter int RING_BYTES = RING_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  in_item_t              item,
  output logic                  done,
  output out_item_t             result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  ctl_t ctl;

  // Sequencing of each item.
  msrb_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .ctl   (ctl)
  );

  // Pointers, ring memory and result.
  msrb_datapath #(
    .CHANNELS   (CHANNELS),
    .RING_BYTES (RING_BYTES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .item      (item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .result    (result)
  );

endmodule

>>> sv/msrb_ctrl.sv
// Controller of the ring buffers: sequences each item through execute and respond phases.
// Depends on msrb_pkg for the control struct.
module msrb_ctrl
  import msrb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  output logic done,
  output ctl_t ctl
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_RESP = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       accept;

  // A new item may enter while the previous result is being shown.
  assign busy   = (state == ST_EXEC);
  assign accept = start && !busy;

  always_comb begin
    case (state)
      ST_IDLE: begin
        state_next = accept ? ST_EXEC : ST_IDLE;
      end
      ST_EXEC: begin
        state_next = ST_RESP;
      end
      ST_RESP: begin
        state_next = accept ? ST_EXEC : ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Commands to the datapath.
  assign ctl.load = accept;
  assign ctl.exec = (state == ST_EXEC);
  assign ctl.resp = (state == ST_RESP);
  assign done     = ctl.resp;

  // An accepted item is executed in the next cycle.
  a_accept_exec: assert property (@(posedge clk) disable iff (rst) accept |=> ctl.exec)
    else $error("accepted item not executed");
  // Execution is always followed by exactly one result strobe.
  a_exec_done: assert property (@(posedge clk) disable iff (rst) ctl.exec |=> done)
    else $error("executed item gave no result");
  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held for two cycles");

endmodule

>>> sv/msrb_datapath.sv
// Datapath of the ring buffers: configuration, per-channel pointers, ring memory, results.
// Depends on msrb_pkg for item types, codes and the control struct.
module msrb_datapath
  import msrb_pkg::*;
#(
  parameter int CHANNELS   = CHANNELS_DEF,
  parameter int RING_BYTES = RING_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ctl_t                  ctl,
  input  in_item_t              item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output out_item_t             result
);

  localparam int PTR_W     = $clog2(RING_BYTES);
  localparam int CH_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int ADDR_W    = CH_IDX_W + 1 + PTR_W;
  localparam int MEM_DEPTH = 2 ** ADDR_W;
  localparam logic [PTR_W:0]   RING_SIZE = (PTR_W + 1)'(RING_BYTES);
  localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(RING_BYTES - 1);

  // Configuration registers.
  logic [3:0] channel_count;
  logic [7:0] channel_open_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count     <= 4'd8;
      channel_open_mask <= 8'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CHANNEL_COUNT: channel_count     <= cfg_data[3:0];
        REG_OPEN_MASK:     channel_open_mask <= cfg_data;
        default:           ;
      endcase
    end
  end

  // Item register, loaded when the item is accepted.
  in_item_t item_q;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      item_q <= item;
    end
  end

  // Per-channel head and tail pointers.
  logic [PTR_W-1:0] rx_head [CHANNELS];
  logic [PTR_W-1:0] rx_tail [CHANNELS];
  logic [PTR_W-1:0] tx_head [CHANNELS];
  logic [PTR_W-1:0] tx_tail [CHANNELS];

  logic [CH_IDX_W-1:0] ci;
  logic                ch_ok;
  logic [PTR_W-1:0]    rxh, rxt, txh, txt;
  logic [PTR_W:0]      rxc_wide, txf_wide;
  logic [PTR_W-1:0]    rxc, txf;

  assign ci    = CH_IDX_W'(item_q.channel);
  assign ch_ok = ({1'b0, item_q.channel} < channel_count)
              && (32'(item_q.channel) < CHANNELS)
              && channel_open_mask[item_q.channel];
  assign rxh = rx_head[ci];
  assign rxt = rx_tail[ci];
  assign txh = tx_head[ci];
  assign txt = tx_tail[ci];

  // Ring levels before the access.
  assign rxc_wide = (rxh >= rxt) ? ({1'b0, rxh} - {1'b0, rxt})
                                 : (RING_SIZE - {1'b0, rxt} + {1'b0, rxh});
  assign txf_wide = (txh >= txt) ? ({1'b0, txh} - {1'b0, txt})
                                 : (RING_SIZE - {1'b0, txt} + {1'b0, txh});
  assign rxc = rxc_wide[PTR_W-1:0];
  assign txf = txf_wide[PTR_W-1:0];

  // Decide what the access does.
  logic tx_wr_ok, rx_rd_ok, rx_put_ok, tx_take_ok, ring_busy;
  logic [PTR_W-1:0] sel_ptr;
  logic             ring_sel;

  always_comb begin
    tx_wr_ok   = 1'b0;
    rx_rd_ok   = 1'b0;
    rx_put_ok  = 1'b0;
    tx_take_ok = 1'b0;
    ring_busy  = 1'b0;
    sel_ptr    = txh;
    ring_sel   = RING_TX;
    case (item_q.cmd)
      CMD_HOST_TX_WRITE: begin
        ring_busy = (txf == PTR_LAST);
        tx_wr_ok  = ch_ok && !ring_busy;
        sel_ptr   = txh;
        ring_sel  = RING_TX;
      end
      CMD_HOST_RX_READ: begin
        ring_busy = (rxc == '0);
        rx_rd_ok  = ch_ok && !ring_busy;
        sel_ptr   = rxt;
        ring_sel  = RING_RX;
      end
      CMD_LINE_RX_PUT: begin
        ring_busy = (rxc == PTR_LAST);
        rx_put_ok = ch_ok && !ring_busy;
        sel_ptr   = rxh;
        ring_sel  = RING_RX;
      end
      CMD_LINE_TX_TAKE: begin
        ring_busy  = (txf == '0);
        tx_take_ok = ch_ok && !ring_busy;
        sel_ptr    = txt;
        ring_sel   = RING_TX;
      end
      default: begin
        ring_busy = 1'b0;
      end
    endcase
  end

  // Advanced pointer, wrapping at the ring size.
  logic [PTR_W-1:0] ptr_adv;
  assign ptr_adv = (sel_ptr == PTR_LAST) ? '0 : (sel_ptr + 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        rx_head[i] <= '0;
        rx_tail[i] <= '0;
        tx_head[i] <= '0;
        tx_tail[i] <= '0;
      end
    end else if (ctl.exec) begin
      if (tx_wr_ok)   tx_head[ci] <= ptr_adv;
      if (rx_rd_ok)   rx_tail[ci] <= ptr_adv;
      if (rx_put_ok)  rx_head[ci] <= ptr_adv;
      if (tx_take_ok) tx_tail[ci] <= ptr_adv;
    end
  end

  // Ring memory: at most one byte written or read per item.
  logic [7:0]        ring_mem [MEM_DEPTH];
  logic [7:0]        rdata_q;
  logic [ADDR_W-1:0] mem_addr;
  logic              mem_we, mem_re;

  assign mem_addr = {ci, ring_sel, sel_ptr};
  assign mem_we   = ctl.exec && (tx_wr_ok || rx_put_ok);
  assign mem_re   = ctl.exec && (rx_rd_ok || tx_take_ok);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem[mem_addr] <= item_q.data_in;
    end
    if (mem_re) begin
      rdata_q <= ring_mem[mem_addr];
    end
  end

  // Levels after the access: each success moves a level by one.
  logic [PTR_W-1:0] rxc_after, txf_after, txr_after;
  assign rxc_after = rxc + PTR_W'(rx_put_ok) - PTR_W'(rx_rd_ok);
  assign txf_after = txf + PTR_W'(tx_wr_ok) - PTR_W'(tx_take_ok);
  assign txr_after = PTR_LAST - txf_after;

  // Result registers, shown during the respond phase.
  logic [1:0]         status_q;
  logic [COUNT_W-1:0] rx_count_q, tx_room_q;
  logic               rd_flag_q;

  always_ff @(posedge clk) begin
    if (ctl.exec) begin
      rd_flag_q <= rx_rd_ok || tx_take_ok;
      if (!ch_ok) begin
        status_q   <= STATUS_REFUSED;
        rx_count_q <= '0;
        tx_room_q  <= '0;
      end else begin
        status_q   <= ring_busy ? STATUS_RING : STATUS_DONE;
        rx_count_q <= COUNT_W'(rxc_after);
        tx_room_q  <= COUNT_W'(txr_after);
      end
    end
  end

  assign result.data_out = rd_flag_q ? rdata_q : 8'd0;
  assign result.status   = status_q;
  assign result.rx_count = rx_count_q;
  assign result.tx_room  = tx_room_q;

  // A refused channel reports nothing but its status.
  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
      (ctl.resp && result.status == STATUS_REFUSED) |->
      (result.rx_count == '0 && result.tx_room == '0 && result.data_out == 8'd0))
    else $error("refused access reported levels or data");
  // No byte is returned unless the access completed.
  a_fail_no_data: assert property (@(posedge clk) disable iff (rst)
      (ctl.resp && result.status != STATUS_DONE) |-> !rd_flag_q)
    else $error("failed access read the ring");
  // Every result carries one of the defined status codes.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
      ctl.resp |-> (result.status == STATUS_DONE || result.status == STATUS_RING
                    || result.status == STATUS_REFUSED))
    else $error("result status code undefined");

endmodule
